@@ src/ats_pkg.sv @@
// ----------------------------------------------------------------------------
// ats_pkg
// Shared widths, types and saturation helpers for the advection stencil.
// ----------------------------------------------------------------------------
package ats_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 16;
	localparam int SPACING_WIDTH = VALUE_WIDTH - 1;
	localparam int PROD_WIDTH    = 2 * VALUE_WIDTH;
	localparam int WIDE_WIDTH    = PROD_WIDTH + 2;
	localparam int QUEUE_DEPTH   = 16;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int FRONT_STAGES  = 7;
	localparam int CFG_IDX_WIDTH = 1;

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [WIDE_WIDTH-1:0]  wide_t;
	typedef logic [VALUE_WIDTH-1:0]        den_t;
	typedef logic [SPACING_WIDTH-1:0]      spacing_t;
	typedef logic [QUEUE_AW:0]             qcount_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_INFLOW_SCALE  = 1'b0,
		CFG_INFLOW_OFFSET = 1'b1
	} cfg_reg_t;

	// one cell as it travels through the front stages
	typedef struct packed {
		val_t     center;
		val_t     west;
		val_t     east;
		val_t     south;
		val_t     north;
		logic [3:0] nbr_valid;
		logic     center_valid;
		val_t     speed_x;
		val_t     speed_y;
		spacing_t spacing_x;
		spacing_t spacing_y;
		val_t     tend;
		val_t     inflow;
		val_t     lo_x;
		val_t     lo_y;
		val_t     hi_x;
		val_t     hi_y;
		val_t     diff_x;
		val_t     diff_y;
	} ats_cell_t;

	// queue entry handed from front to back
	typedef struct packed {
		prod_t prod_x;
		prod_t prod_y;
		den_t  den_x;
		den_t  den_y;
		val_t  tend;
		logic  center_valid;
	} ats_entry_t;

	function automatic wide_t wext(input val_t v);
		return wide_t'(v);
	endfunction

	// clamp to the signed value range
	function automatic val_t sat_wide(input wide_t v);
		wide_t hi_v;
		wide_t lo_v;
		hi_v = {{(WIDE_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
		lo_v = ~hi_v;
		if (v > hi_v) return hi_v[VALUE_WIDTH-1:0];
		if (v < lo_v) return lo_v[VALUE_WIDTH-1:0];
		return v[VALUE_WIDTH-1:0];
	endfunction

	// twice the spacing, a zero spacing counting as one LSB
	function automatic den_t make_den(input spacing_t s);
		if (s == '0) return den_t'(2);
		return {s, 1'b0};
	endfunction

endpackage

@@ src/ats_front.sv @@
// ----------------------------------------------------------------------------
// ats_front
// Accepts cells, forms the inflow value, resolves missing neighbours and
// multiplies speed by the centred difference. Credit-based input ready.
// ----------------------------------------------------------------------------
module ats_front import ats_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ats_cell_t  in_cell,
	input  val_t       inflow_scale,
	input  val_t       inflow_offset,
	input  qcount_t    queue_count,
	output logic       push,
	output ats_entry_t push_entry
);

	logic       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	ats_cell_t  cell_s1, cell_s2, cell_s3, cell_s4, cell_s5, cell_s6;
	prod_t      scale_prod_s2;
	ats_entry_t entry_s7;

	logic [QUEUE_AW+1:0] credit_used;
	logic                accept;
	prod_t               prod_adj;
	prod_t               prod_trunc;
	val_t                inflow_c;
	val_t                lo_x_c, lo_y_c, hi_x_c, hi_y_c;
	ats_cell_t           nxt_s3, nxt_s4, nxt_s5, nxt_s6;
	ats_entry_t          nxt_s7;

	// hold back input while queue plus stages in flight could overflow
	always_comb begin
		credit_used = (QUEUE_AW+2)'(queue_count)
			+ (QUEUE_AW+2)'($countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}));
		in_ready = credit_used < (QUEUE_AW+2)'(QUEUE_DEPTH);
		accept   = in_valid && in_ready;
	end

	// inflow: truncate product toward zero, add offset, saturate
	always_comb begin
		prod_adj   = scale_prod_s2
			+ (scale_prod_s2[PROD_WIDTH-1] ? prod_t'((1 << FRACTION_BITS) - 1) : prod_t'(0));
		prod_trunc = prod_adj >>> FRACTION_BITS;
		inflow_c   = sat_wide(wide_t'(prod_trunc) + wext(inflow_offset));
		nxt_s3        = cell_s2;
		nxt_s3.inflow = inflow_c;
	end

	// low neighbour: inflow, or extrapolation when flow leaves through it
	always_comb begin
		lo_x_c = cell_s3.west;
		if (!cell_s3.nbr_valid[0]) begin
			lo_x_c = cell_s3.inflow;
			if (cell_s3.speed_x[VALUE_WIDTH-1] && cell_s3.nbr_valid[1])
				lo_x_c = sat_wide(wext(cell_s3.center) + wext(cell_s3.center)
					- wext(cell_s3.east));
		end
		lo_y_c = cell_s3.south;
		if (!cell_s3.nbr_valid[2]) begin
			lo_y_c = cell_s3.inflow;
			if (cell_s3.speed_y[VALUE_WIDTH-1] && cell_s3.nbr_valid[3])
				lo_y_c = sat_wide(wext(cell_s3.center) + wext(cell_s3.center)
					- wext(cell_s3.north));
		end
		nxt_s4      = cell_s3;
		nxt_s4.lo_x = lo_x_c;
		nxt_s4.lo_y = lo_y_c;
	end

	// high neighbour: uses the resolved low value
	always_comb begin
		hi_x_c = cell_s4.east;
		if (!cell_s4.nbr_valid[1]) begin
			hi_x_c = cell_s4.inflow;
			if (!cell_s4.speed_x[VALUE_WIDTH-1] && cell_s4.speed_x != '0)
				hi_x_c = sat_wide(wext(cell_s4.center) + wext(cell_s4.center)
					- wext(cell_s4.lo_x));
		end
		hi_y_c = cell_s4.north;
		if (!cell_s4.nbr_valid[3]) begin
			hi_y_c = cell_s4.inflow;
			if (!cell_s4.speed_y[VALUE_WIDTH-1] && cell_s4.speed_y != '0)
				hi_y_c = sat_wide(wext(cell_s4.center) + wext(cell_s4.center)
					- wext(cell_s4.lo_y));
		end
		nxt_s5      = cell_s4;
		nxt_s5.hi_x = hi_x_c;
		nxt_s5.hi_y = hi_y_c;
	end

	// centred differences, then speed times difference for the queue entry
	always_comb begin
		nxt_s6        = cell_s5;
		nxt_s6.diff_x = sat_wide(wext(cell_s5.hi_x) - wext(cell_s5.lo_x));
		nxt_s6.diff_y = sat_wide(wext(cell_s5.hi_y) - wext(cell_s5.lo_y));

		nxt_s7.prod_x       = cell_s6.speed_x * cell_s6.diff_x;
		nxt_s7.prod_y       = cell_s6.speed_y * cell_s6.diff_y;
		nxt_s7.den_x        = make_den(cell_s6.spacing_x);
		nxt_s7.den_y        = make_den(cell_s6.spacing_y);
		nxt_s7.tend         = cell_s6.tend;
		nxt_s7.center_valid = cell_s6.center_valid;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (accept) cell_s1 <= in_cell;

		cell_s2       <= cell_s1;
		scale_prod_s2 <= inflow_scale * cell_s1.center;

		cell_s3  <= nxt_s3;
		cell_s4  <= nxt_s4;
		cell_s5  <= nxt_s5;
		cell_s6  <= nxt_s6;
		entry_s7 <= nxt_s7;
	end

	assign push       = v_s7;
	assign push_entry = entry_s7;

endmodule

@@ src/ats_queue.sv @@
// ----------------------------------------------------------------------------
// ats_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ats_queue import ats_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ats_entry_t push_entry,
	input  logic       pop,
	output logic       not_empty,
	output ats_entry_t head,
	output qcount_t    count
);

	ats_entry_t             mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    wr_ptr_q, rd_ptr_q;
	qcount_t                count_q;
	logic                   do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + qcount_t'(push) - qcount_t'(do_pop);
		end
	end

	// store beat
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != qcount_t'(QUEUE_DEPTH) || do_pop))
		else $error("queue pushed while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qcount_t'(QUEUE_DEPTH))
		else $error("queue level beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue level did not rise on push");

endmodule

@@ src/ats_back.sv @@
// ----------------------------------------------------------------------------
// ats_back
// Pipelined restoring dividers for both axis terms, then the saturated
// subtractions and the output register. Whole pipeline freezes on stall.
// ----------------------------------------------------------------------------
module ats_back import ats_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  ats_entry_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output val_t       tendency_out,
	output logic       cell_updated
);

	logic                   vld_s   [PROD_WIDTH+1];
	logic [VALUE_WIDTH-1:0] rem_x_s [PROD_WIDTH+1];
	logic [VALUE_WIDTH-1:0] rem_y_s [PROD_WIDTH+1];
	logic [PROD_WIDTH-1:0]  quo_x_s [PROD_WIDTH+1];
	logic [PROD_WIDTH-1:0]  quo_y_s [PROD_WIDTH+1];
	logic                   neg_x_s [PROD_WIDTH+1];
	logic                   neg_y_s [PROD_WIDTH+1];
	den_t                   den_x_s [PROD_WIDTH+1];
	den_t                   den_y_s [PROD_WIDTH+1];
	val_t                   tend_s  [PROD_WIDTH+1];
	logic                   cv_s    [PROD_WIDTH+1];

	logic  en;
	logic  v_f1;
	val_t  t1_f1;
	wide_t qy_f1;
	logic  cv_f1;
	val_t  tend_f1;
	wide_t qx_c, qy_c;
	logic  out_valid_q;
	val_t  tend_out_q;
	logic  updated_q;

	// freeze everything while the output beat waits
	assign en  = !out_valid_q || out_ready;
	assign pop = en && head_valid;

	// load: take magnitudes of the products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_x_s[0] <= '0;
			rem_y_s[0] <= '0;
			quo_x_s[0] <= head.prod_x[PROD_WIDTH-1] ? -head.prod_x : head.prod_x;
			quo_y_s[0] <= head.prod_y[PROD_WIDTH-1] ? -head.prod_y : head.prod_y;
			neg_x_s[0] <= head.prod_x[PROD_WIDTH-1];
			neg_y_s[0] <= head.prod_y[PROD_WIDTH-1];
			den_x_s[0] <= head.den_x;
			den_y_s[0] <= head.den_y;
			tend_s[0]  <= head.tend;
			cv_s[0]    <= head.center_valid;
		end
	end

	// one quotient bit per stage and axis
	for (genvar k = 1; k <= PROD_WIDTH; k++) begin : g_div
		logic [VALUE_WIDTH:0] sh_x, sh_y;
		logic                 ge_x, ge_y;

		always_comb begin
			sh_x = {rem_x_s[k-1], quo_x_s[k-1][PROD_WIDTH-1]};
			sh_y = {rem_y_s[k-1], quo_y_s[k-1][PROD_WIDTH-1]};
			ge_x = sh_x >= {1'b0, den_x_s[k-1]};
			ge_y = sh_y >= {1'b0, den_y_s[k-1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_x_s[k] <= ge_x ? VALUE_WIDTH'(sh_x - {1'b0, den_x_s[k-1]})
					: sh_x[VALUE_WIDTH-1:0];
				rem_y_s[k] <= ge_y ? VALUE_WIDTH'(sh_y - {1'b0, den_y_s[k-1]})
					: sh_y[VALUE_WIDTH-1:0];
				quo_x_s[k] <= {quo_x_s[k-1][PROD_WIDTH-2:0], ge_x};
				quo_y_s[k] <= {quo_y_s[k-1][PROD_WIDTH-2:0], ge_y};
				neg_x_s[k] <= neg_x_s[k-1];
				neg_y_s[k] <= neg_y_s[k-1];
				den_x_s[k] <= den_x_s[k-1];
				den_y_s[k] <= den_y_s[k-1];
				tend_s[k]  <= tend_s[k-1];
				cv_s[k]    <= cv_s[k-1];
			end
		end
	end

	// restore quotient signs
	always_comb begin
		qx_c = neg_x_s[PROD_WIDTH] ? -wide_t'({2'b00, quo_x_s[PROD_WIDTH]})
			: wide_t'({2'b00, quo_x_s[PROD_WIDTH]});
		qy_c = neg_y_s[PROD_WIDTH] ? -wide_t'({2'b00, quo_y_s[PROD_WIDTH]})
			: wide_t'({2'b00, quo_y_s[PROD_WIDTH]});
	end

	// subtract x term, then y term, each saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_f1        <= vld_s[PROD_WIDTH];
			out_valid_q <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1_f1      <= sat_wide(wext(tend_s[PROD_WIDTH]) - qx_c);
			qy_f1      <= qy_c;
			cv_f1      <= cv_s[PROD_WIDTH];
			tend_f1    <= tend_s[PROD_WIDTH];
			tend_out_q <= cv_f1 ? sat_wide(wext(t1_f1) - qy_f1) : tend_f1;
			updated_q  <= cv_f1;
		end
	end

	assign out_valid    = out_valid_q;
	assign tendency_out = tend_out_q;
	assign cell_updated = updated_q;

endmodule

@@ src/advection_tendency_stencil.sv @@
// ----------------------------------------------------------------------------
// advection_tendency_stencil
// Centred-difference advection tendency for one grid cell per beat.
// ----------------------------------------------------------------------------
// Stages: 7 front stages, the queue, 64 divider stages per axis and
// 2 subtract stages.
// Throughput: one cell per cycle unless out_ready or input credits stall it.
// Input ready uses credits over the 16-entry queue and the front stages.
// Reset clears all valid bits and queue pointers; both registers reset to 0.
module advection_tendency_stencil import ats_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [VALUE_WIDTH-1:0]   cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  val_t                     center_value,
	input  val_t                     west_value,
	input  val_t                     east_value,
	input  val_t                     south_value,
	input  val_t                     north_value,
	input  logic [3:0]               neighbor_valid,
	input  logic                     center_valid,
	input  val_t                     speed_x,
	input  val_t                     speed_y,
	input  spacing_t                 spacing_x,
	input  spacing_t                 spacing_y,
	input  val_t                     tendency_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output val_t                     tendency_out,
	output logic                     cell_updated
);

	val_t       inflow_scale_q, inflow_offset_q;
	ats_cell_t  in_cell;
	logic       push, pop, head_valid;
	ats_entry_t push_entry, head;
	qcount_t    queue_count;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflow_scale_q  <= '0;
			inflow_offset_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_INFLOW_SCALE:  inflow_scale_q  <= cfg_data;
				CFG_INFLOW_OFFSET: inflow_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// gather the input beat
	always_comb begin
		in_cell              = '0;
		in_cell.center       = center_value;
		in_cell.west         = west_value;
		in_cell.east         = east_value;
		in_cell.south        = south_value;
		in_cell.north        = north_value;
		in_cell.nbr_valid    = neighbor_valid;
		in_cell.center_valid = center_valid;
		in_cell.speed_x      = speed_x;
		in_cell.speed_y      = speed_y;
		in_cell.spacing_x    = spacing_x;
		in_cell.spacing_y    = spacing_y;
		in_cell.tend         = tendency_in;
	end

	ats_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_cell       (in_cell),
		.inflow_scale  (inflow_scale_q),
		.inflow_offset (inflow_offset_q),
		.queue_count   (queue_count),
		.push          (push),
		.push_entry    (push_entry)
	);

	ats_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.not_empty  (head_valid),
		.head       (head),
		.count      (queue_count)
	);

	ats_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tendency_out (tendency_out),
		.cell_updated (cell_updated)
	);

endmodule
